>>> rtl/clsw_pkg.sv
package clsw_pkg;

    // Display geometry
    localparam int LINE_WIDTH   = 16;   // 1..32
    localparam int LINE_COUNT   = 2;    // 1..2
    localparam int SHADOW_DEPTH = LINE_WIDTH * LINE_COUNT;
    localparam int ADDR_W       = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

    // Cursor: bit 6 is the row, bits 5:0 the column
    localparam int CUR_W   = 7;
    localparam int COL_W   = 6;
    localparam int ROW_BIT = 6;

    localparam logic [COL_W-1:0] LINE_WIDTH_COL = COL_W'(LINE_WIDTH);
    localparam logic [CUR_W-1:0] ROW1_HOME      = 7'h40;
    localparam logic [7:0]       CHAR_SPACE     = 8'h20;
    localparam logic [7:0]       CMD_CLEAR      = 8'h01;

    // Stream widths
    localparam int S_TDATA_W = 16;  // column, row, character, zero fill
    localparam int S_TUSER_W = 2;   // mode
    localparam int M_TDATA_W = 8;   // bus byte
    localparam int M_TUSER_W = 1;   // register select

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_GOTO  = 2'd1,
        MODE_PUT   = 2'd2,
        MODE_EOL   = 2'd3
    } t_mode;

    // Engine to output stage: one bus write, or end of request
    typedef struct packed {
        logic       push;
        logic       fin;
        logic [7:0] data;
        logic       rs;
    } t_emit;

    // Engine to shadow memory
    typedef struct packed {
        logic              clear;
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

endpackage

>>> rtl/clsw_shadow_mem.sv
module clsw_shadow_mem
    import clsw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0]              r_mem [SHADOW_DEPTH];
    logic [SHADOW_DEPTH-1:0] r_valid;
    logic [7:0]              r_rdata;
    logic                    r_rvalid;

    // Storage, one port: write or read per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata  <= r_mem[i_req.addr];
            r_rvalid <= r_valid[i_req.addr];
        end
    end

    // Entry valid bits; an unwritten entry reads as a space
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : CHAR_SPACE;

endmodule

>>> rtl/clsw_out.sv
module clsw_out
    import clsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_emit                i_emit,
    output logic                 o_emit_ready,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [M_TDATA_W-1:0] o_tdata,
    output logic [M_TUSER_W-1:0] o_tuser,
    output logic                 o_tlast
);

    // One write is held back until it is known whether it is the last.
    logic       r_pvalid;
    logic [7:0] r_pdata;
    logic       r_prs;
    logic       r_ovalid;
    logic [7:0] r_odata;
    logic       r_ors;
    logic       r_olast;
    logic       w_out_free;
    logic       w_push;
    logic       w_fin;

    assign w_out_free   = !r_ovalid || i_tready;
    assign o_emit_ready = !r_pvalid || w_out_free;
    assign w_push       = i_emit.push && o_emit_ready;
    assign w_fin        = i_emit.fin && o_emit_ready && r_pvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            if ((w_push && r_pvalid) || w_fin) begin
                r_ovalid <= 1'b1;
            end
            if (w_push) begin
                r_pvalid <= 1'b1;
            end else if (w_fin) begin
                r_pvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_push && r_pvalid) || w_fin) begin
            r_odata <= r_pdata;
            r_ors   <= r_prs;
            r_olast <= w_fin;
        end
        if (w_push) begin
            r_pdata <= i_emit.data;
            r_prs   <= i_emit.rs;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ors;
    assign o_tlast  = r_olast;

endmodule

>>> rtl/clsw_engine.sv
module clsw_engine
    import clsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [COL_W-1:0] i_column,
    input  logic             i_row,
    input  logic [7:0]       i_character,
    output t_mem_req         o_mem_req,
    input  logic [7:0]       i_mem_rdata,
    output t_emit            o_emit,
    input  logic             i_emit_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_LOOK,
        S_CMP,
        S_ADDR,
        S_DATA,
        S_FIN
    } t_state;

    t_state           r_state;
    logic             r_shadow_en;
    logic [CUR_W-1:0] r_dcur;
    logic [CUR_W-1:0] r_wcur;
    logic [CUR_W-1:0] r_tgt;
    logic [7:0]       r_char;
    logic             r_eol;

    t_mode             w_mode;
    logic              w_accept;
    logic [COL_W-1:0]  w_wcol;
    logic [COL_W-1:0]  w_dcol;
    logic              w_wcol_end;
    logic              w_dcol_end;
    logic              w_row_ok;
    logic              w_differ;
    logic [ADDR_W-1:0] w_idx;

    assign w_mode     = t_mode'(i_mode);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wcol     = r_wcur[COL_W-1:0];
    assign w_dcol     = r_dcur[COL_W-1:0];
    assign w_wcol_end = (w_wcol >= LINE_WIDTH_COL);
    assign w_dcol_end = (w_dcol >= LINE_WIDTH_COL);
    assign w_row_ok   = (LINE_COUNT > 1) || !r_wcur[ROW_BIT];
    assign w_differ   = (i_mem_rdata != r_char);
    assign w_idx      = r_wcur[ROW_BIT] ? ADDR_W'(LINE_WIDTH) + ADDR_W'(w_wcol)
                                        : ADDR_W'(w_wcol);

    // Memory requests: clear on accepting a clear request, read in LOOK, write back in CMP
    always_comb begin
        o_mem_req       = '0;
        o_mem_req.addr  = w_idx;
        o_mem_req.wdata = r_char;
        o_mem_req.clear = w_accept && (w_mode == MODE_CLEAR);
        o_mem_req.re    = (r_state == S_LOOK) && r_shadow_en && !w_wcol_end && w_row_ok;
        o_mem_req.we    = (r_state == S_CMP) && w_differ;
    end

    always_comb begin
        o_emit = '0;
        unique case (r_state)
            S_CLR: begin
                o_emit.push = 1'b1;
                o_emit.data = CMD_CLEAR;
            end
            S_ADDR: begin
                o_emit.push = 1'b1;
                o_emit.data = {1'b1, r_tgt};
            end
            S_DATA: begin
                o_emit.push = 1'b1;
                o_emit.data = r_char;
                o_emit.rs   = 1'b1;
            end
            S_FIN: begin
                o_emit.fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shadow_en <= 1'b1;
            r_dcur      <= '0;
            r_wcur      <= '0;
            r_tgt       <= '0;
            r_char      <= '0;
            r_eol       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_shadow_en <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_mode)
                            MODE_CLEAR: begin
                                r_dcur  <= '0;
                                r_wcur  <= '0;
                                r_state <= S_CLR;
                            end
                            MODE_GOTO: begin
                                if (r_shadow_en) begin
                                    r_wcur  <= {i_row, i_column};
                                    r_state <= S_FIN;
                                end else begin
                                    r_tgt   <= {i_row, i_column};
                                    r_state <= S_ADDR;
                                end
                            end
                            MODE_PUT: begin
                                r_char  <= i_character;
                                r_eol   <= 1'b0;
                                r_state <= S_LOOK;
                            end
                            MODE_EOL: begin
                                r_char  <= CHAR_SPACE;
                                r_eol   <= 1'b1;
                                r_state <= S_LOOK;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    if (i_emit_ready) begin
                        r_state <= S_FIN;
                    end
                end
                S_LOOK: begin
                    if (r_shadow_en) begin
                        if (w_wcol_end) begin
                            // row done: end of line moves to row one
                            if (r_eol && !r_wcur[ROW_BIT]) begin
                                r_wcur <= ROW1_HOME;
                            end
                            r_state <= S_FIN;
                        end else if (!w_row_ok) begin
                            // no such line: cursor moves, nothing stored
                            r_wcur  <= r_wcur + 1'b1;
                            r_state <= r_eol ? S_LOOK : S_FIN;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end else begin
                        if (w_dcol_end) begin
                            if (r_eol && !r_dcur[ROW_BIT]) begin
                                r_tgt   <= ROW1_HOME;
                                r_state <= S_ADDR;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_state <= S_DATA;
                        end
                    end
                end
                S_CMP: begin
                    if (w_differ) begin
                        if (r_wcur != r_dcur) begin
                            r_tgt   <= r_wcur;
                            r_state <= S_ADDR;
                        end else begin
                            r_state <= S_DATA;
                        end
                    end else begin
                        r_wcur  <= r_wcur + 1'b1;
                        r_state <= r_eol ? S_LOOK : S_FIN;
                    end
                end
                S_ADDR: begin
                    if (i_emit_ready) begin
                        r_dcur  <= r_tgt;
                        r_state <= r_shadow_en ? S_DATA : S_FIN;
                    end
                end
                S_DATA: begin
                    if (i_emit_ready) begin
                        r_dcur <= r_dcur + 1'b1;
                        if (r_shadow_en) begin
                            r_wcur <= r_wcur + 1'b1;
                        end
                        r_state <= r_eol ? S_LOOK : S_FIN;
                    end
                end
                S_FIN: begin
                    if (i_emit_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/char_lcd_shadow_writer.sv
// Channel   Dir  Handshake                     Payload
// --------  ---  ----------------------------  -------------------------------------
// request   in   i_s_axis_tvalid/o_s_axis_tready  tuser: mode; tdata: column,row,char
// bus write out  o_m_axis_tvalid/i_m_axis_tready  tdata: byte; tuser: rs; tlast
// config    in   i_cfg_wr_en                   i_cfg_wr_data: shadow_enable
//
// One request at a time. Shadow put character: a column past the row end, or on
// a missing line, stops after the look-up; else read and compare, then, only if
// the character differs, write-back, optional set-address and data; then end.
// End of line walks the row one column per pass, each column a single-port
// shadow memory read followed by its compare. Reset clears the shadow valid bits
// at once; no clearing pass is needed. A stalled master side holds the engine
// only when a write must move out.
module char_lcd_shadow_writer
    import clsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,   // column[5:0], row[6], character[14:7]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,   // mode[1:0]
    // bus write stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,   // bus_byte[7:0]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,   // register_select[0]
    output logic                 o_m_axis_tlast
);

    t_mem_req   w_mem_req;
    logic [7:0] w_mem_rdata;
    t_emit      w_emit;
    logic       w_emit_ready;

    // Sequencer: decodes requests, walks rows, tracks both cursors
    clsw_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_mode        (i_s_axis_tuser),
        .i_column      (i_s_axis_tdata[5:0]),
        .i_row         (i_s_axis_tdata[6]),
        .i_character   (i_s_axis_tdata[14:7]),
        .o_mem_req     (w_mem_req),
        .i_mem_rdata   (w_mem_rdata),
        .o_emit        (w_emit),
        .i_emit_ready  (w_emit_ready)
    );

    // Shadow copy of the screen
    clsw_shadow_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    // Holding stage marks tlast, then output register
    clsw_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_emit       (w_emit),
        .o_emit_ready (w_emit_ready),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata),
        .o_tuser      (o_m_axis_tuser),
        .o_tlast      (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // A clear always produces the clear command as the next bus write
    a_clear_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == MODE_CLEAR))
        |=> (w_emit.push && (w_emit.data == CMD_CLEAR) && !w_emit.rs))
        else $error("clear request did not issue clear command");

    // An idle engine never issues a transfer or an end marker
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!w_emit.push && !w_emit.fin))
        else $error("engine emitting while idle");

    // Shadow memory port: never read and write, and never clear with an access
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_req.we && w_mem_req.re)
        && !(w_mem_req.clear && (w_mem_req.we || w_mem_req.re)))
        else $error("shadow memory access conflict");
`endif

endmodule
